// File: sv/dsfp_pkg.sv
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types and constants for the dust sensor frame parser: header bytes,
// frame lengths, parse phases, result codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  // header and length codes
  localparam logic [7:0]  HDR0       = 8'h42;
  localparam logic [7:0]  HDR1       = 8'h4D;
  localparam logic [15:0] LEN_MEAS   = 16'd28;
  localparam logic [15:0] LEN_REPLY  = 16'd4;
  localparam logic [4:0]  PAY_MEAS   = 5'd26;
  localparam logic [4:0]  PAY_REPLY  = 5'd2;

  // payload word store
  localparam int unsigned NUM_WORDS  = 13;
  localparam int unsigned WADDR_W    = 4;
  localparam logic [3:0]  IDX_VERSION = 4'd12;
  localparam logic [3:0]  IDX_ERROR   = 4'd13;

  // frame kinds
  localparam logic KIND_MEAS  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_SUM_ERR = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_CMD_ERR = 2'd3
  } frame_status_e;

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_PAY   = 3'd4,
    PH_SUMHI = 3'd5,
    PH_SUMLO = 3'd6,
    PH_EMIT  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    SUM_HOLD = 2'd0,
    SUM_LOAD = 2'd1,
    SUM_ADD  = 2'd2
  } sum_op_e;

  typedef enum logic [2:0] {
    RES_BAD_LEN = 3'd0,
    RES_SUM_ERR = 3'd1,
    RES_CMD_ERR = 3'd2,
    RES_REPLY   = 3'd3,
    RES_MEAS    = 3'd4
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    sum_op_e  sum_op;
    logic     len_hi_ld;
    logic     len_chk;
    logic     pay_wr;
    logic     sum_hi_ld;
    logic     emit_clr;
    logic     emit_inc;
    logic     out_ld;
    res_sel_e out_sel;
  } dsfp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_hdr0;
    logic is_hdr1;
    logic len_meas;
    logic len_reply;
    logic pay_done;
    logic sum_ok;
    logic cmd_ok;
    logic is_reply;
    logic emit_last;
    logic out_free;
  } dsfp_sts_t;

endpackage

// File: sv/dsfp_ctrl.sv
// ----------------------------------------------------------------------------
// dsfp_ctrl
// Parse state machine: header hunt, length check, payload and sum bytes,
// and sequencing of the result run for a measurement frame.
// ----------------------------------------------------------------------------
module dsfp_ctrl
  import dsfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dsfp_sts_t sts_i,
  output dsfp_cmd_t cmd_o
);

  phase_e phase_q, phase_d;
  logic   in_acc;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // no byte taken while emitting or while the result slot is full and not being taken
  assign in_ready_o = (phase_q != PH_EMIT) && sts_i.out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    phase_d = phase_q;
    cmd_o   = '{sum_op: SUM_HOLD, out_sel: RES_MEAS, default: 1'b0};
    case (phase_q)
      PH_HUNT0: begin
        if (in_acc && sts_i.is_hdr0) begin
          cmd_o.sum_op = SUM_LOAD;
          phase_d      = PH_HUNT1;
        end
      end
      PH_HUNT1: begin
        if (in_acc) begin
          if (sts_i.is_hdr1) begin
            cmd_o.sum_op = SUM_ADD;
            phase_d      = PH_LENHI;
          end else if (sts_i.is_hdr0) begin
            cmd_o.sum_op = SUM_LOAD;
          end else begin
            phase_d = PH_HUNT0;
          end
        end
      end
      PH_LENHI: begin
        if (in_acc) begin
          cmd_o.sum_op    = SUM_ADD;
          cmd_o.len_hi_ld = 1'b1;
          phase_d         = PH_LENLO;
        end
      end
      PH_LENLO: begin
        if (in_acc) begin
          cmd_o.sum_op  = SUM_ADD;
          cmd_o.len_chk = 1'b1;
          if (sts_i.len_meas || sts_i.len_reply) begin
            phase_d = PH_PAY;
          end else begin
            cmd_o.out_ld  = 1'b1;
            cmd_o.out_sel = RES_BAD_LEN;
            phase_d       = PH_HUNT0;
          end
        end
      end
      PH_PAY: begin
        if (in_acc) begin
          cmd_o.sum_op = SUM_ADD;
          cmd_o.pay_wr = 1'b1;
          if (sts_i.pay_done) begin
            phase_d = PH_SUMHI;
          end
        end
      end
      PH_SUMHI: begin
        if (in_acc) begin
          cmd_o.sum_hi_ld = 1'b1;
          phase_d         = PH_SUMLO;
        end
      end
      PH_SUMLO: begin
        if (in_acc) begin
          phase_d = PH_HUNT0;
          if (!sts_i.sum_ok) begin
            cmd_o.out_ld  = 1'b1;
            cmd_o.out_sel = RES_SUM_ERR;
          end else if (sts_i.is_reply) begin
            cmd_o.out_ld  = 1'b1;
            cmd_o.out_sel = sts_i.cmd_ok ? RES_REPLY : RES_CMD_ERR;
          end else begin
            cmd_o.emit_clr = 1'b1;
            phase_d        = PH_EMIT;
          end
        end
      end
      PH_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_sel  = RES_MEAS;
          cmd_o.emit_inc = 1'b1;
          if (sts_i.emit_last) begin
            phase_d = PH_HUNT0;
          end
        end
      end
      default: begin
        phase_d = PH_HUNT0;
      end
    endcase
  end

endmodule

// File: sv/dsfp_datapath.sv
// ----------------------------------------------------------------------------
// dsfp_datapath
// Byte sum, length and sum capture, payload word store, expected command
// register and the registered result slot.
// ----------------------------------------------------------------------------
module dsfp_datapath
  import dsfp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    rx_byte_i,
  input  logic          cfg_valid_i,
  input  logic [7:0]    expected_command_i,
  input  logic          out_ready_i,
  input  dsfp_cmd_t     cmd_i,
  output dsfp_sts_t     sts_o,
  output logic          out_valid_o,
  output logic          frame_kind_o,
  output logic [3:0]    word_index_o,
  output logic [15:0]   word_value_o,
  output logic [1:0]    frame_status_o,
  output logic          last_of_frame_o
);

  logic [7:0]  exp_cmd_q;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  len_hi_q;
  logic [7:0]  sum_hi_q;
  logic [4:0]  pos_q, pos_d;
  logic        reply_q;
  logic [3:0]  emit_q;
  logic        out_valid_q;
  logic [15:0] words_q [NUM_WORDS];

  logic [15:0]        len_w, rx_sum;
  logic [4:0]         pos_inc, need;
  logic [WADDR_W-1:0] wr_addr, rd_addr;
  logic [15:0]        rd_word;

  // result slot
  logic          kind_d;
  logic [3:0]    idx_d;
  logic [15:0]   val_d;
  frame_status_e stat_d;
  logic          last_d;
  logic          kind_q;
  logic [3:0]    idx_q;
  logic [15:0]   val_q;
  logic [1:0]    stat_q;
  logic          last_q;

  assign len_w   = {len_hi_q, rx_byte_i};
  assign rx_sum  = {sum_hi_q, rx_byte_i};
  assign pos_inc = pos_q + 5'd1;
  assign need    = reply_q ? PAY_REPLY : PAY_MEAS;
  assign wr_addr = pos_q[4:1];
  assign rd_addr = (emit_q >= IDX_VERSION) ? IDX_VERSION : emit_q;
  assign rd_word = words_q[rd_addr];

  // status to the controller
  always_comb begin
    sts_o.is_hdr0   = (rx_byte_i == HDR0);
    sts_o.is_hdr1   = (rx_byte_i == HDR1);
    sts_o.len_meas  = (len_w == LEN_MEAS);
    sts_o.len_reply = (len_w == LEN_REPLY);
    sts_o.pay_done  = (pos_inc >= need);
    sts_o.sum_ok    = (rx_sum == sum_q);
    sts_o.cmd_ok    = (rd_word[15:8] == exp_cmd_q);
    sts_o.is_reply  = reply_q;
    sts_o.emit_last = (emit_q == IDX_ERROR);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // running byte sum
  always_comb begin
    case (cmd_i.sum_op)
      SUM_LOAD: sum_d = {8'h00, HDR0};
      SUM_ADD:  sum_d = sum_q + {8'h00, rx_byte_i};
      default:  sum_d = sum_q;
    endcase
  end

  // payload byte position
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.len_chk) begin
      pos_d = 5'd0;
    end else if (cmd_i.pay_wr) begin
      pos_d = pos_inc;
    end
  end

  // frame control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cmd_q <= 8'h00;
      sum_q     <= 16'h0000;
      len_hi_q  <= 8'h00;
      sum_hi_q  <= 8'h00;
      pos_q     <= 5'd0;
      reply_q   <= 1'b0;
      emit_q    <= 4'd0;
    end else begin
      if (cfg_valid_i) begin
        exp_cmd_q <= expected_command_i;
      end
      sum_q <= sum_d;
      pos_q <= pos_d;
      if (cmd_i.len_hi_ld) begin
        len_hi_q <= rx_byte_i;
      end
      if (cmd_i.sum_hi_ld) begin
        sum_hi_q <= rx_byte_i;
      end
      if (cmd_i.len_chk && (sts_o.len_meas || sts_o.len_reply)) begin
        reply_q <= sts_o.len_reply;
      end
      if (cmd_i.emit_clr) begin
        emit_q <= 4'd0;
      end else if (cmd_i.emit_inc) begin
        emit_q <= (emit_q == IDX_ERROR) ? 4'd0 : emit_q + 4'd1;
      end
    end
  end

  // payload word store: high byte first, low byte merged in
  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_wr && (wr_addr < WADDR_W'(NUM_WORDS))) begin
      if (!pos_q[0]) begin
        words_q[wr_addr] <= {rx_byte_i, 8'h00};
      end else begin
        words_q[wr_addr][7:0] <= rx_byte_i;
      end
    end
  end

  // result formation
  always_comb begin
    kind_d = KIND_MEAS;
    idx_d  = 4'd0;
    val_d  = 16'h0000;
    stat_d = ST_GOOD;
    last_d = 1'b1;
    case (cmd_i.out_sel)
      RES_BAD_LEN: begin
        val_d  = len_w;
        stat_d = ST_BAD_LEN;
      end
      RES_SUM_ERR: begin
        kind_d = reply_q;
        val_d  = rx_sum;
        stat_d = ST_SUM_ERR;
      end
      RES_CMD_ERR: begin
        kind_d = KIND_REPLY;
        val_d  = {8'h00, rd_word[15:8]};
        stat_d = ST_CMD_ERR;
      end
      RES_REPLY: begin
        kind_d = KIND_REPLY;
        val_d  = {8'h00, rd_word[7:0]};
      end
      RES_MEAS: begin
        idx_d  = emit_q;
        last_d = (emit_q == IDX_ERROR);
        if (emit_q == IDX_VERSION) begin
          val_d = {8'h00, rd_word[15:8]};
        end else if (emit_q == IDX_ERROR) begin
          val_d = {8'h00, rd_word[7:0]};
        end else begin
          val_d = rd_word;
        end
      end
      default: begin
        val_d = 16'h0000;
      end
    endcase
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_ld || (out_valid_q && !out_ready_i);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      kind_q <= kind_d;
      idx_q  <= idx_d;
      val_q  <= val_d;
      stat_q <= stat_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_kind_o    = kind_q;
  assign word_index_o    = idx_q;
  assign word_value_o    = val_q;
  assign frame_status_o  = stat_q;
  assign last_of_frame_o = last_q;

endmodule

// File: sv/dust_sensor_frame_parser_unit.sv
// An error, bad-length or reply result is registered at the edge that takes its
// closing byte; a measurement run starts in the cycle after that edge.
// Throughput: one byte per cycle, none while the output register holds an untaken
// result; a good measurement frame then emits 14 results, one per cycle when taken.
// No byte is accepted during that run. Reset (rst_ni low, asynchronous): header
// hunt, sum, counters and expected command cleared; payload word store kept.
// ----------------------------------------------------------------------------
// dust_sensor_frame_parser_unit
// Top level: byte-stream frame parser built from a parse controller and a
// datapath holding the sum, payload words and result register.
// ----------------------------------------------------------------------------
module dust_sensor_frame_parser_unit
  import dsfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  expected_command_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_kind_o,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic [1:0]  frame_status_o,
  output logic        last_of_frame_o
);

  dsfp_cmd_t cmd;
  dsfp_sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // parse controller
  dsfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  dsfp_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rx_byte_i          (rx_byte_i),
    .cfg_valid_i        (cfg_valid_i),
    .expected_command_i (expected_command_i),
    .out_ready_i        (out_ready_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .frame_kind_o       (frame_kind_o),
    .word_index_o       (word_index_o),
    .word_value_o       (word_value_o),
    .frame_status_o     (frame_status_o),
    .last_of_frame_o    (last_of_frame_o)
  );

endmodule

// File: dv/dust_sensor_frame_parser_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dust_sensor_frame_parser_unit_tb
// Feeds serial bytes into the frame parser: a few hand-built frames and hunt
// sequences, then random measurement frames, replies, corrupted sums, bad
// lengths and line noise under three command settings. A scoreboard tracks
// the parse state of the byte stream and checks every result field by field.
// ----------------------------------------------------------------------------
module dust_sensor_frame_parser_unit_tb;
  import dsfp_pkg::*;

  localparam int unsigned HALF_HI      = 6;
  localparam int unsigned HALF_LO      = 6;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned PHASE_BYTES  = 48;
  localparam int unsigned SETTLE_IDLE  = 4;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic          kind;
    logic [3:0]    index;
    logic [15:0]   value;
    frame_status_e status;
    logic          last;
  } frame_result_t;

  // byte-stream parse tracker and result store
  class frame_scoreboard;
    phase_e        state;
    logic [4:0]    pay_pos;
    logic [15:0]   sum;
    logic          reply;
    logic [15:0]   words[NUM_WORDS];
    logic [7:0]    sum_hi;
    logic [7:0]    len_hi;
    logic [7:0]    command;
    frame_result_t result_q[$];
    int unsigned   mismatches;

    function new();
      state      = PH_HUNT0;
      pay_pos    = '0;
      sum        = '0;
      reply      = 1'b0;
      sum_hi     = '0;
      len_hi     = '0;
      command    = '0;
      mismatches = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void set_command(logic [7:0] c);
      command = c;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    function void push(logic kind, logic [3:0] index, logic [15:0] value,
                       frame_status_e status, logic last);
      frame_result_t r;
      r.kind   = kind;
      r.index  = index;
      r.value  = value;
      r.status = status;
      r.last   = last;
      result_q.push_back(r);
    endfunction

    // advance the parse by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [15:0] len;
      logic [15:0] rx_sum;
      logic [3:0]  w;
      logic [4:0]  need;
      case (state)
        PH_HUNT0: begin
          if (b == HDR0) begin
            sum   = 16'(HDR0);
            state = PH_HUNT1;
          end
        end
        PH_HUNT1: begin
          // a repeated first header byte keeps waiting for the second
          if (b == HDR1) begin
            sum   = sum + 16'(b);
            state = PH_LENHI;
          end else if (b == HDR0) begin
            sum = 16'(HDR0);
          end else begin
            state = PH_HUNT0;
          end
        end
        PH_LENHI: begin
          len_hi = b;
          sum    = sum + 16'(b);
          state  = PH_LENLO;
        end
        PH_LENLO: begin
          len     = {len_hi, b};
          sum     = sum + 16'(b);
          pay_pos = '0;
          if (len == LEN_MEAS) begin
            reply = 1'b0;
            state = PH_PAY;
          end else if (len == LEN_REPLY) begin
            reply = 1'b1;
            state = PH_PAY;
          end else begin
            push(KIND_MEAS, 4'd0, len, ST_BAD_LEN, 1'b1);
            state = PH_HUNT0;
          end
        end
        PH_PAY: begin
          w    = 4'(pay_pos >> 1);
          need = reply ? PAY_REPLY : PAY_MEAS;
          sum  = sum + 16'(b);
          if (!pay_pos[0]) words[w] = {b, 8'h00};
          else             words[w][7:0] = b;
          pay_pos = pay_pos + 5'd1;
          if (pay_pos >= need) state = PH_SUMHI;
        end
        PH_SUMHI: begin
          sum_hi = b;
          state  = PH_SUMLO;
        end
        default: begin
          // trailing sum low byte closes the frame
          rx_sum = {sum_hi, b};
          state  = PH_HUNT0;
          if (rx_sum != sum) begin
            push(reply, 4'd0, rx_sum, ST_SUM_ERR, 1'b1);
          end else if (reply) begin
            if (words[0][15:8] == command)
              push(KIND_REPLY, 4'd0, {8'h00, words[0][7:0]}, ST_GOOD, 1'b1);
            else
              push(KIND_REPLY, 4'd0, {8'h00, words[0][15:8]}, ST_CMD_ERR, 1'b1);
          end else begin
            for (int i = 0; i < 12; i++)
              push(KIND_MEAS, 4'(i), words[i], ST_GOOD, 1'b0);
            push(KIND_MEAS, IDX_VERSION, {8'h00, words[12][15:8]}, ST_GOOD, 1'b0);
            push(KIND_MEAS, IDX_ERROR, {8'h00, words[12][7:0]}, ST_GOOD, 1'b1);
          end
        end
      endcase
    endfunction

    // compare one taken result against the oldest expectation
    function void check_result(logic kind, logic [3:0] index, logic [15:0] value,
                               logic [1:0] status, logic last);
      frame_result_t exp_r;
      if (result_q.size() == 0) begin
        $error("unexpected result: kind %0d index %0d value %h status %0d",
               kind, index, value, status);
        mismatches++;
        return;
      end
      exp_r = result_q.pop_front();
      if (kind !== exp_r.kind) begin
        $error("frame_kind: expected %0d, got %0d", exp_r.kind, kind);
        mismatches++;
      end
      if (index !== exp_r.index) begin
        $error("word_index: expected %0d, got %0d", exp_r.index, index);
        mismatches++;
      end
      if (value !== exp_r.value) begin
        $error("word_value: expected %h, got %h", exp_r.value, value);
        mismatches++;
      end
      if (status !== exp_r.status) begin
        $error("frame_status: expected %0d, got %0d", exp_r.status, status);
        mismatches++;
      end
      if (last !== exp_r.last) begin
        $error("last_of_frame: expected %0d, got %0d", exp_r.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  expected_command_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        frame_kind_o;
  logic [3:0]  word_index_o;
  logic [15:0] word_value_o;
  logic [1:0]  frame_status_o;
  logic        last_of_frame_o;

  frame_scoreboard sb = new();

  bit          tx_steady;
  bit          rx_steady;
  bit          long_hold_req;
  int unsigned bytes_sent;

  dust_sensor_frame_parser_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .expected_command_i(expected_command_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_kind_o      (frame_kind_o),
    .word_index_o      (word_index_o),
    .word_value_o      (word_value_o),
    .frame_status_o    (frame_status_o),
    .last_of_frame_o   (last_of_frame_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #(HALF_LO) clk_i = 1'b1;
    #(HALF_HI) clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // payload words lean toward the extremes
  function automatic logic [15:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(frame_kind_o, word_index_o, word_value_o, frame_status_o,
                      last_of_frame_o);
  end

  // receiver: random stalls plus one long hold on request
  initial begin
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!rx_steady) stall_left = idle_len();
      end
    end
  end

  // offer one byte and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // append the big-endian trailing sum, optionally corrupted
  function automatic void append_sum(ref byte_q_t q, input bit bad_sum);
    logic [15:0] s;
    s = '0;
    foreach (q[i]) s = s + 16'(q[i]);
    if (bad_sum) s = s ^ 16'($urandom_range(1, 65535));
    q.push_back(s[15:8]);
    q.push_back(s[7:0]);
  endfunction

  task automatic send_meas(input bit bad_sum);
    byte_q_t     q;
    logic [15:0] w;
    q = {HDR0, HDR1, LEN_MEAS[15:8], LEN_MEAS[7:0]};
    for (int i = 0; i < int'(NUM_WORDS); i++) begin
      w = pick_word();
      q.push_back(w[15:8]);
      q.push_back(w[7:0]);
    end
    append_sum(q, bad_sum);
    send_bytes(q);
  endtask

  task automatic send_reply(input logic [7:0] cmd, input logic [7:0] data,
                            input bit bad_sum);
    byte_q_t q;
    q = {HDR0, HDR1, LEN_REPLY[15:8], LEN_REPLY[7:0], cmd, data};
    append_sum(q, bad_sum);
    send_bytes(q);
  endtask

  // any length other than the two legal ones
  task automatic send_bad_length();
    logic [15:0] len;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20)      len = 16'h0000;
    else if (r < 40) len = 16'hFFFF;
    else             len = 16'($urandom);
    if (len == LEN_MEAS || len == LEN_REPLY) len[8] = ~len[8];
    send_bytes({HDR0, HDR1, len[15:8], len[7:0]});
  endtask

  // line noise, rich in header bytes
  task automatic send_noise();
    int unsigned n;
    int unsigned r;
    n = $urandom_range(1, 6);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 25)      send_byte(HDR0);
      else if (r < 35) send_byte(HDR1);
      else             send_byte(8'($urandom));
    end
  endtask

  task automatic send_random_frame();
    int unsigned r;
    logic [7:0]  cmd;
    r   = $urandom_range(0, 99);
    cmd = $urandom_range(0, 1) ? sb.command : 8'($urandom);
    if (r < 35)      send_meas(1'b0);
    else if (r < 55) send_reply(cmd, 8'(pick_word()), 1'b0);
    else if (r < 65) send_meas(1'b1);
    else if (r < 72) send_reply(cmd, 8'($urandom), 1'b1);
    else if (r < 85) send_bad_length();
    else             send_noise();
  endtask

  // write the command register once everything is drained
  task automatic write_command(input logic [7:0] c);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_IDLE) @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    expected_command_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_command(c);
  endtask

  // stimulus
  initial begin
    int unsigned phase_start;
    logic [7:0]  phase_cmd;
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    expected_command_i = '0;
    in_valid_i         = 1'b0;
    rx_byte_i          = '0;
    tx_steady          = 1'b0;
    rx_steady          = 1'b0;
    long_hold_req      = 1'b0;
    bytes_sent         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: good reply, hunt corner cases, command mismatch
    write_command(8'hFF);
    send_reply(8'hFF, 8'h00, 1'b0);
    // restart on a stray byte, repeated first header byte, then a length of
    // 0x0042 whose low byte is not rescanned, so the trailing 0x4D is ignored
    send_bytes({HDR0, 8'h00, HDR0, HDR0, HDR1, 8'h00, HDR0, HDR1});
    send_reply(8'h00, 8'hFF, 1'b0);

    // random phases under different expected commands
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       phase_cmd = 8'h00;
        1:       phase_cmd = 8'($urandom);
        default: phase_cmd = 8'hFF;
      endcase
      write_command(phase_cmd);
      tx_steady   = (ph == 1);
      rx_steady   = (ph == 2);
      phase_start = bytes_sent;
      if (ph == 0) begin
        // receiver stalls for a long stretch while frames keep coming
        long_hold_req = 1'b1;
        send_meas(1'b0);
      end
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_frame();
    end

    // drain
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/dsfp_pkg.sv
sv/dsfp_ctrl.sv
sv/dsfp_datapath.sv
sv/dust_sensor_frame_parser_unit.sv
dv/dust_sensor_frame_parser_unit_tb.sv
